FILE: rtl/core/cppt_pkg.sv
// shared types and constants for the convex polygon point test
package cppt_pkg;

    // control bits that travel with each queued vertex
    typedef struct packed {
        logic opening;
        logic last;
    } t_edge_ctl;

    localparam int unsigned CTL_W       = $bits(t_edge_ctl);
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;
    localparam int unsigned QUEUE_CNT_W = 3;
    localparam int unsigned OUT_TDATA_W = 8;
    localparam int unsigned NUM_DIFFS   = 8;

endpackage

FILE: rtl/core/cppt_front.sv
// front end: accepts vertices, tracks polygon state and forms edge differences
module cppt_front #(
    parameter int unsigned COORD_WIDTH = 24
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    output logic                                             o_ready,
    input  logic signed [COORD_WIDTH-1:0]                    i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0]                    i_vertex_y,
    input  logic signed [COORD_WIDTH-1:0]                    i_query_x,
    input  logic signed [COORD_WIDTH-1:0]                    i_query_y,
    input  logic                                             i_last,
    input  logic                                             i_full,
    output logic                                             o_push,
    output cppt_pkg::t_edge_ctl                              o_ctl,
    output logic [cppt_pkg::NUM_DIFFS*(COORD_WIDTH+1)-1:0]   o_diff
);

    localparam int unsigned DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] r_first_x, r_first_y, n_first_x, n_first_y;
    logic signed [COORD_WIDTH-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_WIDTH-1:0] r_hq_x, r_hq_y, n_hq_x, n_hq_y;
    logic                          r_open, n_open;
    logic                          accept;
    logic signed [COORD_WIDTH-1:0] eq_x, eq_y, ef_x, ef_y;
    logic signed [DW-1:0]          a1, b1, c1, d1, a2, b2, c2, d2;

    function automatic logic signed [COORD_WIDTH:0] sub_ext(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] q
    );
        return $signed({p[COORD_WIDTH-1], p}) - $signed({q[COORD_WIDTH-1], q});
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // query and first vertex as seen by this transaction
    assign eq_x = r_open ? r_hq_x : i_query_x;
    assign eq_y = r_open ? r_hq_y : i_query_y;
    assign ef_x = r_open ? r_first_x : i_vertex_x;
    assign ef_y = r_open ? r_first_y : i_vertex_y;

    // edge from previous vertex to current
    assign a1 = sub_ext(eq_x, r_prev_x);
    assign b1 = sub_ext(i_vertex_y, r_prev_y);
    assign c1 = sub_ext(eq_y, r_prev_y);
    assign d1 = sub_ext(i_vertex_x, r_prev_x);
    // closing edge from current vertex back to first
    assign a2 = sub_ext(eq_x, i_vertex_x);
    assign b2 = sub_ext(ef_y, i_vertex_y);
    assign c2 = sub_ext(eq_y, i_vertex_y);
    assign d2 = sub_ext(ef_x, i_vertex_x);

    assign o_push        = accept;
    assign o_ctl.opening = !r_open;
    assign o_ctl.last    = i_last;
    assign o_diff        = {d2, c2, b2, a2, d1, c1, b1, a1};

    always_comb begin
        n_open    = r_open;
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        n_hq_x    = r_hq_x;
        n_hq_y    = r_hq_y;
        if (accept) begin
            n_first_x = ef_x;
            n_first_y = ef_y;
            n_hq_x    = eq_x;
            n_hq_y    = eq_y;
            n_open    = !i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_x <= n_first_x;
        r_first_y <= n_first_y;
        r_hq_x    <= n_hq_x;
        r_hq_y    <= n_hq_y;
        if (accept) begin
            r_prev_x <= i_vertex_x;
            r_prev_y <= i_vertex_y;
        end
    end

endmodule

FILE: rtl/core/cppt_queue.sv
// small register queue between front and back end
module cppt_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]                 r_mem [cppt_pkg::QUEUE_DEPTH];
    logic [cppt_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [cppt_pkg::QUEUE_CNT_W-1:0] r_count, n_count;
    logic                             do_push, do_pop;

    assign o_full  = (r_count == cppt_pkg::QUEUE_CNT_W'(cppt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/cppt_back.sv
// back end: orientation products, turn tracking and result register
module cppt_back #(
    parameter int unsigned COORD_WIDTH = 24
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    output logic                                             o_pop,
    input  cppt_pkg::t_edge_ctl                              i_ctl,
    input  logic [cppt_pkg::NUM_DIFFS*(COORD_WIDTH+1)-1:0]   i_diff,
    output logic                                             o_m_axis_tvalid,
    input  logic                                             i_m_axis_tready,
    output logic [cppt_pkg::OUT_TDATA_W-1:0]                 o_m_axis_tdata
);

    localparam int unsigned DW = COORD_WIDTH + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned SW = PW + 1;

    logic                 advance;
    logic                 r_a_valid;
    cppt_pkg::t_edge_ctl  r_a_ctl;
    logic signed [PW-1:0] r_p1a, r_p1b, r_p2a, r_p2b;
    logic signed [DW-1:0] a1, b1, c1, d1, a2, b2, c2, d2;
    logic signed [SW-1:0] s1, s2;
    logic                 r_left, r_right, n_left, n_right;
    logic                 r_out_valid, r_inside, n_inside;

    assign a1 = $signed(i_diff[0*DW +: DW]);
    assign b1 = $signed(i_diff[1*DW +: DW]);
    assign c1 = $signed(i_diff[2*DW +: DW]);
    assign d1 = $signed(i_diff[3*DW +: DW]);
    assign a2 = $signed(i_diff[4*DW +: DW]);
    assign b2 = $signed(i_diff[5*DW +: DW]);
    assign c2 = $signed(i_diff[6*DW +: DW]);
    assign d2 = $signed(i_diff[7*DW +: DW]);

    assign advance = !r_out_valid || i_m_axis_tready;
    assign o_pop   = i_valid && advance;

    // sign of each orientation, exact in the widened difference
    assign s1 = $signed({r_p1a[PW-1], r_p1a}) - $signed({r_p1b[PW-1], r_p1b});
    assign s2 = $signed({r_p2a[PW-1], r_p2a}) - $signed({r_p2b[PW-1], r_p2b});

    always_comb begin
        n_left  = r_a_ctl.opening ? 1'b0 : r_left;
        n_right = r_a_ctl.opening ? 1'b0 : r_right;
        if (!r_a_ctl.opening) begin
            n_left  = n_left | s1[SW-1];
            n_right = n_right | (!s1[SW-1] && (s1 != '0));
        end
        if (r_a_ctl.last) begin
            n_left  = n_left | s2[SW-1];
            n_right = n_right | (!s2[SW-1] && (s2 != '0));
        end
        n_inside = !(n_left && n_right);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
        end else if (advance) begin
            r_a_valid   <= i_valid;
            r_out_valid <= r_a_valid && r_a_ctl.last;
            if (r_a_valid) begin
                r_left  <= n_left;
                r_right <= n_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_ctl <= i_ctl;
            r_p1a   <= PW'(a1) * PW'(b1);
            r_p1b   <= PW'(c1) * PW'(d1);
            r_p2a   <= PW'(a2) * PW'(b2);
            r_p2b   <= PW'(c2) * PW'(d2);
        end
        if (advance && r_a_valid) begin
            r_inside <= n_inside;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(cppt_pkg::OUT_TDATA_W-1){1'b0}}, r_inside};

endmodule

FILE: rtl/core/convex_polygon_point_test.sv
// top level of the convex polygon point test
// Decides whether a query point lies inside or on a convex polygon. Vertices
// arrive one per transaction, the final one marked with tlast; the query point
// is taken from the transaction that opens a polygon and ignored on the rest.
// One result transaction follows each tlast vertex, 1 meaning inside or on the
// boundary. A vertex is accepted every clock cycle while the result side keeps
// up; a vertex passes through the front end, a four-entry queue and two back-end
// register stages (four signed multipliers, then the orientation sign) on its
// way to the result. A stalled result holds the back end; the queue then fills
// and tready falls.
module convex_polygon_point_test #(
    parameter int unsigned COORD_WIDTH = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // vertex_x, vertex_y, query_x, query_y, zero fill
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    // last_vertex
    input  logic                                   i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // inside_res, zero fill
    output logic [cppt_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata
);

    localparam int unsigned DIFF_W = cppt_pkg::NUM_DIFFS * (COORD_WIDTH + 1);
    localparam int unsigned Q_W    = DIFF_W + cppt_pkg::CTL_W;

    logic                 push, q_full, q_valid, pop;
    cppt_pkg::t_edge_ctl  push_ctl, pop_ctl;
    logic [DIFF_W-1:0]    push_diff, pop_diff;
    logic [Q_W-1:0]       q_wdata, q_rdata;

    cppt_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_vertex_x ($signed(i_s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH])),
        .i_vertex_y ($signed(i_s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH])),
        .i_query_x  ($signed(i_s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH])),
        .i_query_y  ($signed(i_s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH])),
        .i_last     (i_s_axis_tlast),
        .i_full     (q_full),
        .o_push     (push),
        .o_ctl      (push_ctl),
        .o_diff     (push_diff)
    );

    assign q_wdata  = {push_ctl, push_diff};
    assign pop_ctl  = q_rdata[Q_W-1 -: cppt_pkg::CTL_W];
    assign pop_diff = q_rdata[DIFF_W-1:0];

    cppt_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (q_rdata)
    );

    cppt_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_pop           (pop),
        .i_ctl           (pop_ctl),
        .i_diff          (pop_diff),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

FILE: tb/cppt_inside_checker.sv
// checker that predicts and compares the inside results of the convex polygon point test
`timescale 1ns / 1ps
module cppt_inside_checker #(
    parameter int unsigned COORD_WIDTH = 24,
    parameter int unsigned IN_W        = 96,
    parameter int unsigned OUT_W       = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vtx_valid,
    input  logic             i_vtx_ready,
    // vertex_x, vertex_y, query_x, query_y, zero fill
    input  logic [IN_W-1:0]  i_vtx_data,
    // last_vertex
    input  logic             i_vtx_last,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    // inside_res, zero fill
    input  logic [OUT_W-1:0] i_res_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int unsigned PW = 2 * COORD_WIDTH + 4;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PW-1:0]          t_wide;

    t_coord first_x, first_y, prev_x, prev_y, held_qx, held_qy;
    logic   saw_left, saw_right, poly_open;
    logic   inside_expected[$];
    int     n_fail = 0;

    // sign of (q - o) x (a - o), exact at twice the coordinate width plus four bits
    function automatic int orientation(input t_coord ox, oy, ax, ay, qx, qy);
        t_wide orient_val;
        orient_val = (t_wide'(qx) - t_wide'(ox)) * (t_wide'(ay) - t_wide'(oy))
                   - (t_wide'(qy) - t_wide'(oy)) * (t_wide'(ax) - t_wide'(ox));
        return (orient_val > 0) ? 1 : ((orient_val < 0) ? -1 : 0);
    endfunction

    function automatic void record_turn(input t_coord ox, oy, ax, ay);
        int s;
        s = orientation(ox, oy, ax, ay, held_qx, held_qy);
        if (s > 0) saw_right = 1'b1;
        if (s < 0) saw_left = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_coord vx, vy;
        logic   want;
        if (!i_rst_n) begin
            first_x   = '0;
            first_y   = '0;
            prev_x    = '0;
            prev_y    = '0;
            held_qx   = '0;
            held_qy   = '0;
            saw_left  = 1'b0;
            saw_right = 1'b0;
            poly_open = 1'b0;
            inside_expected.delete();
        end else begin
            if (i_vtx_valid && i_vtx_ready) begin
                vx = i_vtx_data[COORD_WIDTH-1:0];
                vy = i_vtx_data[2*COORD_WIDTH-1 -: COORD_WIDTH];
                if (!poly_open) begin
                    first_x   = vx;
                    first_y   = vy;
                    held_qx   = i_vtx_data[3*COORD_WIDTH-1 -: COORD_WIDTH];
                    held_qy   = i_vtx_data[4*COORD_WIDTH-1 -: COORD_WIDTH];
                    saw_left  = 1'b0;
                    saw_right = 1'b0;
                    poly_open = 1'b1;
                end else begin
                    record_turn(prev_x, prev_y, vx, vy);
                end
                prev_x = vx;
                prev_y = vy;
                if (i_vtx_last) begin
                    // closing edge back to the first vertex
                    record_turn(vx, vy, first_x, first_y);
                    inside_expected.push_back(!(saw_left && saw_right));
                    poly_open = 1'b0;
                end
            end
            if (i_res_valid && i_res_ready) begin
                if (inside_expected.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("result transaction with nothing expected: inside_res=%0b",
                                 i_res_data[0]);
                end else begin
                    want = inside_expected.pop_front();
                    if (i_res_data[0] !== want) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("inside_res mismatch: expected %0b, got %0b",
                                     want, i_res_data[0]);
                    end
                end
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= inside_expected.size();
    end

endmodule

FILE: tb/tb.sv
// stimulus, reset, clock and verdict for the convex polygon point test
`timescale 1ns / 1ps
module tb;

    localparam int unsigned CW    = 24;
    localparam int unsigned IN_W  = ((4 * CW + 7) / 8) * 8;
    localparam int unsigned OUT_W = cppt_pkg::OUT_TDATA_W;
    localparam int COORD_MAX      = 8388607;
    localparam int COORD_MIN      = -8388608;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int STALL_LIMIT    = 1000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             vtx_valid = 1'b0;
    logic             vtx_ready;
    logic [IN_W-1:0]  vtx_data  = '0;
    logic             vtx_last  = 1'b0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    logic [OUT_W-1:0] res_data;

    int fail_count;
    int pending;
    bit src_gaps    = 1'b1;
    bit snk_gaps    = 1'b1;
    int items_sent  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int poly_x[16];
    int poly_y[16];
    int poly_n;

    convex_polygon_point_test #(
        .COORD_WIDTH (CW)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (vtx_valid),
        .o_s_axis_tready (vtx_ready),
        .i_s_axis_tdata  (vtx_data),
        .i_s_axis_tlast  (vtx_last),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    cppt_inside_checker #(
        .COORD_WIDTH (CW),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_vtx_valid  (vtx_valid),
        .i_vtx_ready  (vtx_ready),
        .i_vtx_data   (vtx_data),
        .i_vtx_last   (vtx_last),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side back-pressure in bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (snk_gaps && $urandom_range(0, 7) == 0) begin
            res_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (vtx_valid && vtx_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[convex_polygon_point_test] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int rand_offset(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic void put_vertex(input int k, input int x, input int y);
        poly_x[k] = x;
        poly_y[k] = y;
    endfunction

    task automatic send_vertex(input int vx, input int vy, input int qx, input int qy,
                               input bit last);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            vtx_valid <= 1'b0;
            vtx_data  <= {$urandom, $urandom, $urandom};
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        vtx_valid <= 1'b1;
        vtx_data  <= {qy[CW-1:0], qx[CW-1:0], vy[CW-1:0], vx[CW-1:0]};
        vtx_last  <= last;
        @(posedge clk);
        while (!vtx_ready) @(posedge clk);
        items_sent++;
    endtask

    // query travels on the opening vertex, later vertices carry junk there
    task automatic send_polygon(input int qx, input int qy);
        for (int i = 0; i < poly_n; i++)
            send_vertex(poly_x[i], poly_y[i], (i == 0) ? qx : int'($urandom),
                        (i == 0) ? qy : int'($urandom), i == poly_n - 1);
    endtask

    initial begin
        int rand_start, p, kind, span, cx, cy, qx, qy, w, h, t, k;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single vertex polygons
        poly_n = 1;
        put_vertex(0, COORD_MAX, COORD_MIN);
        send_polygon(COORD_MIN, COORD_MAX);
        put_vertex(0, -1, -1);
        send_polygon(0, 0);

        // full range square, centre query
        poly_n = 4;
        put_vertex(0, COORD_MIN, COORD_MIN);
        put_vertex(1, COORD_MAX, COORD_MIN);
        put_vertex(2, COORD_MAX, COORD_MAX);
        put_vertex(3, COORD_MIN, COORD_MAX);
        send_polygon(0, 0);

        // small triangle, far query
        poly_n = 3;
        put_vertex(0, 0, 0);
        put_vertex(1, 256, 0);
        put_vertex(2, 0, 256);
        send_polygon(COORD_MAX, COORD_MAX);

        // query on an edge
        put_vertex(0, 0, 0);
        put_vertex(1, 512, 0);
        put_vertex(2, 512, 512);
        send_polygon(256, 0);

        // two vertex polygon, query off the segment
        poly_n = 2;
        put_vertex(0, COORD_MIN, 0);
        put_vertex(1, COORD_MAX, 0);
        send_polygon(0, 1);

        // full range square the other way round, query on a corner
        poly_n = 4;
        put_vertex(0, COORD_MIN, COORD_MAX);
        put_vertex(1, COORD_MAX, COORD_MAX);
        put_vertex(2, COORD_MAX, COORD_MIN);
        put_vertex(3, COORD_MIN, COORD_MIN);
        send_polygon(COORD_MIN, COORD_MAX);

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            p        = items_sent - rand_start;
            src_gaps = (p < 400) || (p >= 700 && p < 1000) || (p >= 1300 && p < 1450);
            snk_gaps = (p < 400) || (p >= 1000 && p < 1450);

            span = 1 << $urandom_range(1, 21);
            cx   = rand_offset(1 << 22);
            cy   = rand_offset(1 << 22);
            qx   = cx + rand_offset(span + span / 2);
            qy   = cy + rand_offset(span + span / 2);
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    poly_n = 3;
                    for (k = 0; k < 3; k++) put_vertex(k, $urandom, $urandom);
                    qx = $urandom;
                    qy = $urandom;
                end
                1, 2, 3: begin
                    poly_n = 3;
                    for (k = 0; k < 3; k++)
                        put_vertex(k, cx + rand_offset(span), cy + rand_offset(span));
                end
                4, 5: begin
                    poly_n = 4;
                    w = $urandom_range(0, span);
                    h = $urandom_range(0, span);
                    put_vertex(0, cx - w, cy - h);
                    put_vertex(1, cx + w, cy - h);
                    put_vertex(2, cx + w, cy + h);
                    put_vertex(3, cx - w, cy + h);
                    if ($urandom_range(0, 3) == 0) begin
                        qx = cx + w;
                        qy = cy + rand_offset(h);
                    end
                end
                6, 7: begin
                    poly_n = 6;
                    put_vertex(0, cx + span, cy);
                    put_vertex(1, cx + span / 2, cy + span);
                    put_vertex(2, cx - span / 2, cy + span);
                    put_vertex(3, cx - span, cy);
                    put_vertex(4, cx - span / 2, cy - span);
                    put_vertex(5, cx + span / 2, cy - span);
                end
                8: begin
                    poly_n = $urandom_range(1, 2);
                    for (k = 0; k < poly_n; k++)
                        put_vertex(k, cx + rand_offset(span), cy + rand_offset(span));
                end
                default: begin
                    poly_n = $urandom_range(1, 8);
                    for (k = 0; k < poly_n; k++) put_vertex(k, $urandom, $urandom);
                    qx = $urandom;
                    qy = $urandom;
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                for (k = 0; k < poly_n / 2; k++) begin
                    t                     = poly_x[k];
                    poly_x[k]             = poly_x[poly_n - 1 - k];
                    poly_x[poly_n - 1 - k] = t;
                    t                     = poly_y[k];
                    poly_y[k]             = poly_y[poly_n - 1 - k];
                    poly_y[poly_n - 1 - k] = t;
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                k  = $urandom_range(0, poly_n - 1);
                qx = poly_x[k];
                qy = poly_y[k];
            end
            send_polygon(qx, qy);
        end

        vtx_valid <= 1'b0;
        vtx_last  <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[convex_polygon_point_test] OK");
        else
            $display("[convex_polygon_point_test] ERROR");
        $finish;
    end

endmodule
